[hw/rtl/rgbhsv_pkg.sv]
// Shared types, widths and constants for the RGB to HSV converter.
`timescale 1ns / 1ps
package rgbhsv_pkg;

  localparam int CH_W   = 8;
  localparam int HUE_W  = 9;
  localparam int SUM_W  = 10;

  // restoring divider: 16-bit dividend, 9-bit divisor, 8 quotient bits
  localparam int DIV_NW = 16;
  localparam int DIV_DW = 9;
  localparam int DIV_QW = 8;

  localparam logic [SUM_W-1:0] HUE_WRAP = 10'd360;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // data carried alongside the two dividers
  typedef struct packed {
    sector_t           sector;
    logic              gray;
    logic [CH_W-1:0]   val;
    logic [CH_W-1:0]   alpha;
  } side_t;

  // quotient is raw hue + 60; adding this lands on hue + 360
  function automatic logic [SUM_W-1:0] hue_offset(input sector_t sec);
    logic [SUM_W-1:0] off;
    case (sec)
      SEC_RED:   off = 10'd300;
      SEC_GREEN: off = 10'd420;
      SEC_BLUE:  off = 10'd540;
      default:   off = 10'd300;
    endcase
    return off;
  endfunction

endpackage

[hw/rtl/rgb_to_hsv_8bit_core.sv]
// RGB to HSV converter, 8-bit channels, alpha passed through: top level.
//
// Takes one RGBA pixel per clock and returns hue (0..359, rounded half up),
// saturation (255*(max-min)/max, truncated), value (largest channel) and
// alpha. Gray pixels give hue 0 and saturation 0; ties for the largest
// channel go to red, then green. Throughput is one pixel per clock while the
// output side is not stalled. A front stage finds max, min and the sector, a
// second forms the dividends, eight stages of a restoring divider (one
// quotient bit each, hue and saturation side by side) follow, and a last
// stage wraps the hue into the output register.
// Every stage holds while the stage after it is full and stalled, so
// in_tready drops only when the whole pipeline is full and out_tready is low.
`timescale 1ns / 1ps
module rgb_to_hsv_8bit_core
  import rgbhsv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // red[7:0], green[15:8], blue[23:16], alpha_in[31:24]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // hue[8:0], saturation[16:9], brightness[24:17],
                                  // alpha_out[32:25], zero[39:33]
);

  localparam int NSTG = DIV_QW + 3;
  localparam int S_DIV0 = 2;
  localparam int S_OUT = NSTG - 1;

  logic [NSTG-1:0] valid_r;
  logic [NSTG-1:0] valid_nxt;
  logic [NSTG:0]   adv;

  // stall chain: a stage loads when empty or when the next one moves
  always_comb begin
    adv[NSTG] = out_tready;
    for (int i = NSTG-1; i >= 0; i--) begin
      adv[i] = ~valid_r[i] | adv[i+1];
    end
    valid_nxt = {valid_r[NSTG-2:0], in_tvalid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (adv[i]) begin
          valid_r[i] <= valid_nxt[i];
        end
      end
    end
  end

  assign in_tready  = adv[0];
  assign out_tvalid = valid_r[S_OUT];

  // ---- stage 0: max, min, sector, shifted hue numerator
  logic [CH_W-1:0] red, green, blue, alpha_in;
  logic [CH_W-1:0] mx, mn, hp, hq, dif;
  sector_t         sec;
  logic [CH_W:0]   sn;

  assign red      = in_tdata[7:0];
  assign green    = in_tdata[15:8];
  assign blue     = in_tdata[23:16];
  assign alpha_in = in_tdata[31:24];

  always_comb begin
    if (red >= green && red >= blue) begin
      sec = SEC_RED;
    end else if (green >= blue) begin
      sec = SEC_GREEN;
    end else begin
      sec = SEC_BLUE;
    end
    case (sec)
      SEC_RED: begin
        mx = red;   hp = green; hq = blue;
      end
      SEC_GREEN: begin
        mx = green; hp = blue;  hq = red;
      end
      SEC_BLUE: begin
        mx = blue;  hp = red;   hq = green;
      end
      default: begin
        mx = red;   hp = green; hq = blue;
      end
    endcase
    mn = (red < green) ? red : green;
    mn = (mn < blue) ? mn : blue;
    dif = mx - mn;
    // (p - q) + d lies in 0..2d
    sn = {1'b0, hp} + {1'b0, dif} - {1'b0, hq};
  end

  side_t           side0_r;
  logic [CH_W-1:0] dif0_r;
  logic [CH_W:0]   sn0_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      side0_r <= '{sector: sec, gray: (dif == '0), val: mx, alpha: alpha_in};
      dif0_r  <= dif;
      sn0_r   <= sn;
    end
  end

  // ---- stage 1: dividends and divisors
  // hue quotient = (120*sn + d) / 2d, saturation quotient = 255*d / max
  side_t             side1_r;
  logic [DIV_NW-1:0] hnum1_r, snum1_r;
  logic [DIV_DW-1:0] hden1_r, sden1_r;
  logic [DIV_NW-1:0] hnum_nxt, snum_nxt;

  always_comb begin
    hnum_nxt = DIV_NW'(sn0_r) * DIV_NW'(120) + DIV_NW'(dif0_r);
    snum_nxt = {dif0_r, 8'd0} - DIV_NW'(dif0_r);
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      side1_r <= side0_r;
      hnum1_r <= hnum_nxt;
      snum1_r <= snum_nxt;
      hden1_r <= {dif0_r, 1'b0};
      sden1_r <= {1'b0, side0_r.val};
    end
  end

  // ---- divider stages
  logic [DIV_QW-1:0] hquo, squo;
  side_t             side_r [DIV_QW];

  rgbhsv_div u_hue_div (
    .clk   (clk),
    .adv   (adv[S_DIV0 +: DIV_QW]),
    .num_i (hnum1_r),
    .den_i (hden1_r),
    .quo_o (hquo)
  );

  rgbhsv_div u_sat_div (
    .clk   (clk),
    .adv   (adv[S_DIV0 +: DIV_QW]),
    .num_i (snum1_r),
    .den_i (sden1_r),
    .quo_o (squo)
  );

  for (genvar k = 0; k < DIV_QW; k++) begin : g_side
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (adv[S_DIV0]) begin
          side_r[0] <= side1_r;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (adv[S_DIV0+k]) begin
          side_r[k] <= side_r[k-1];
        end
      end
    end
  end

  // ---- output stage: offset and wrap hue, force gray to zero
  side_t            side_last;
  logic [SUM_W-1:0] hue_sum, hue_wrap;
  logic [HUE_W-1:0] hue_nxt;
  logic [CH_W-1:0]  sat_nxt;

  assign side_last = side_r[DIV_QW-1];

  always_comb begin
    hue_sum  = {2'b00, hquo} + hue_offset(side_last.sector);
    hue_wrap = (hue_sum >= HUE_WRAP) ? hue_sum - HUE_WRAP : hue_sum;
    hue_nxt  = side_last.gray ? '0 : hue_wrap[HUE_W-1:0];
    sat_nxt  = side_last.gray ? '0 : squo;
  end

  logic [HUE_W-1:0] hue_r;
  logic [CH_W-1:0]  sat_r, val_r, alpha_r;

  always_ff @(posedge clk) begin
    if (adv[S_OUT]) begin
      hue_r   <= hue_nxt;
      sat_r   <= sat_nxt;
      val_r   <= side_last.val;
      alpha_r <= side_last.alpha;
    end
  end

  assign out_tdata = {7'd0, alpha_r, val_r, sat_r, hue_r};

  // ---- checks
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[8:0] < 9'd360))
    else $error("hue out of range");

  a_gray_hue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[16:9] == 8'd0) |-> (out_tdata[8:0] == 9'd0))
    else $error("zero saturation with non-zero hue");

  a_black_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[24:17] == 8'd0) |-> (out_tdata[16:9] == 8'd0))
    else $error("black pixel with non-zero saturation");

  a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled while output side free");

endmodule

[hw/rtl/rgbhsv_div.sv]
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
module rgbhsv_div
  import rgbhsv_pkg::*;
(
  input  logic              clk,
  input  logic [DIV_QW-1:0] adv,
  input  logic [DIV_NW-1:0] num_i,
  input  logic [DIV_DW-1:0] den_i,
  output logic [DIV_QW-1:0] quo_o
);

  logic [DIV_NW-1:0] rem_r [DIV_QW-1];
  logic [DIV_DW-1:0] den_r [DIV_QW-1];
  logic [DIV_QW-1:0] quo_r [DIV_QW];

  for (genvar k = 0; k < DIV_QW; k++) begin : g_step
    logic [DIV_NW-1:0] rem_in;
    logic [DIV_DW-1:0] den_in;
    logic [DIV_QW-1:0] quo_in;
    logic [DIV_NW:0]   den_sh;
    logic [DIV_NW:0]   trial;
    logic [DIV_QW-1:0] quo_nxt;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    assign den_sh = {{(DIV_NW+1-DIV_DW){1'b0}}, den_in} << (DIV_QW-1-k);
    assign trial  = {1'b0, rem_in} - den_sh;

    always_comb begin
      quo_nxt = quo_in;
      quo_nxt[DIV_QW-1-k] = ~trial[DIV_NW];
    end

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        quo_r[k] <= quo_nxt;
      end
    end

    if (k < DIV_QW-1) begin : g_carry
      logic [DIV_NW-1:0] rem_nxt;

      assign rem_nxt = trial[DIV_NW] ? rem_in : trial[DIV_NW-1:0];

      always_ff @(posedge clk) begin
        if (adv[k]) begin
          rem_r[k] <= rem_nxt;
          den_r[k] <= den_in;
        end
      end
    end
  end

  assign quo_o = quo_r[DIV_QW-1];

endmodule

[verif/tb_rgb_to_hsv_8bit_core.sv]
// Self-checking testbench for the RGB to HSV converter core.
`timescale 1ns / 1ps
module tb_rgb_to_hsv_8bit_core
  import rgbhsv_pkg::*;
();

  localparam int N_RANDOM   = 1700;
  localparam int QUIET_MAX  = 4000;   // cycles with no transfer on either side
  localparam int LONG_HOLD  = 80;     // receiver hold-off, well beyond pipeline depth
  localparam int HOLD_AT    = 300;    // pixels accepted before the long hold-off
  localparam int DRAIN_AT   = 900;    // random pixel index at which the sender drains
  localparam int MAX_REPORT = 10;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  sat;
    logic [CH_W-1:0]  val;
    logic [CH_W-1:0]  alpha;
  } hsv_t;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    logic [CH_W-1:0] a;
    logic            fixed;   // want is typed in; else predicted
    hsv_t            want;
  } pixel_row_t;

  localparam int N_DIRECTED = 20;
  localparam pixel_row_t DIRECTED [N_DIRECTED] = '{
    '{8'd0,   8'd0,   8'd0,   8'h00, 1'b1, '{9'd0,   8'd0,   8'd0,   8'h00}}, // black
    '{8'd0,   8'd0,   8'd0,   8'hFF, 1'b1, '{9'd0,   8'd0,   8'd0,   8'hFF}},
    '{8'd255, 8'd255, 8'd255, 8'hA5, 1'b1, '{9'd0,   8'd0,   8'd255, 8'hA5}}, // white
    '{8'd128, 8'd128, 8'd128, 8'h5A, 1'b1, '{9'd0,   8'd0,   8'd128, 8'h5A}}, // mid gray
    '{8'd255, 8'd0,   8'd0,   8'hFF, 1'b1, '{9'd0,   8'd255, 8'd255, 8'hFF}},
    '{8'd0,   8'd255, 8'd0,   8'h00, 1'b1, '{9'd120, 8'd255, 8'd255, 8'h00}},
    '{8'd0,   8'd0,   8'd255, 8'h80, 1'b1, '{9'd240, 8'd255, 8'd255, 8'h80}},
    '{8'd255, 8'd255, 8'd0,   8'h01, 1'b1, '{9'd60,  8'd255, 8'd255, 8'h01}}, // red/green tie
    '{8'd255, 8'd0,   8'd255, 8'h7F, 1'b1, '{9'd300, 8'd255, 8'd255, 8'h7F}}, // red/blue tie
    '{8'd0,   8'd255, 8'd255, 8'hFE, 1'b1, '{9'd180, 8'd255, 8'd255, 8'hFE}}, // green/blue tie
    '{8'd1,   8'd0,   8'd0,   8'h33, 1'b1, '{9'd0,   8'd255, 8'd1,   8'h33}},
    '{8'd0,   8'd1,   8'd1,   8'hCC, 1'b1, '{9'd180, 8'd255, 8'd1,   8'hCC}},
    '{8'd200, 8'd10,  8'd50,  8'h12, 1'b0, '0},  // red largest, hue wraps
    '{8'd130, 8'd11,  8'd10,  8'h34, 1'b0, '0},  // hue exactly half a degree
    '{8'd254, 8'd1,   8'd0,   8'h56, 1'b0, '0},
    '{8'd10,  8'd200, 8'd199, 8'h78, 1'b0, '0},
    '{8'd100, 8'd50,  8'd200, 8'h9A, 1'b0, '0},
    '{8'd255, 8'd254, 8'd254, 8'hBC, 1'b0, '0},  // near-gray, span of one
    '{8'd1,   8'd255, 8'd0,   8'hDE, 1'b0, '0},
    '{8'd90,  8'd90,  8'd91,  8'hF0, 1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  hsv_t pending_hsv [$];
  int   bad_count = 0;
  int   accepted_px = 0;
  int   quiet_cycles = 0;

  rgb_to_hsv_8bit_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expected HSV for one packed RGBA pixel
  function automatic hsv_t convert_pixel(input logic [31:0] px);
    int unsigned r, g, b, top, bottom, span, lead, trail, base, q;
    sector_t     sec;
    hsv_t        res;
    r = 32'(px[7:0]);
    g = 32'(px[15:8]);
    b = 32'(px[23:16]);
    top    = (r >= g && r >= b) ? r : (g >= b ? g : b);
    bottom = (r <= g && r <= b) ? r : (g <= b ? g : b);
    res.val   = top[CH_W-1:0];
    res.alpha = px[31:24];
    res.hue   = '0;
    res.sat   = '0;
    if (top != bottom) begin
      span = top - bottom;
      res.sat = CH_W'((255 * span) / top);
      if (r == top) sec = SEC_RED;
      else if (g == top) sec = SEC_GREEN;
      else sec = SEC_BLUE;
      case (sec)
        SEC_RED:   begin lead = g; trail = b; base = 0;   end
        SEC_GREEN: begin lead = b; trail = r; base = 120; end
        default:   begin lead = r; trail = g; base = 240; end
      endcase
      // numerator biased by span stays non-negative, so division floors;
      // q carries an extra 60 degrees
      q = (120 * (lead + span - trail) + span) / (2 * span);
      res.hue = HUE_W'((q + base + 300) % 360);
    end
    return res;
  endfunction

  // back-to-back when calm; else mostly back-to-back, sometimes a short gap, rarely a long one
  function automatic int pick_gap(input bit calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] random_pixel();
    logic [7:0] r, g, b, a;
    r = 8'($urandom);
    g = 8'($urandom);
    b = 8'($urandom);
    a = 8'($urandom);
    case ($urandom_range(0, 9))
      0: begin g = r; b = r; end   // gray
      1: g = r;
      2: b = g;
      3: b = r;
      4: begin
        r = ($urandom_range(0, 1) != 0) ? 8'(8'hFF - $urandom_range(0, 2))
                                        : 8'($urandom_range(0, 2));
        g = ($urandom_range(0, 1) != 0) ? 8'(8'hFF - $urandom_range(0, 2))
                                        : 8'($urandom_range(0, 2));
        b = ($urandom_range(0, 1) != 0) ? 8'(8'hFF - $urandom_range(0, 2))
                                        : 8'($urandom_range(0, 2));
      end
      default: ;
    endcase
    return {a, b, g, r};
  endfunction

  // sender
  initial begin : drive_pixels
    pixel_row_t  row;
    logic [31:0] px;
    int          gap;
    bit          calm;
    bit          drain;
    calm = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int idx = 0; idx < N_DIRECTED + N_RANDOM; idx++) begin
      if ($urandom_range(0, 79) == 0) calm = !calm;
      if (idx < N_DIRECTED) begin
        row = DIRECTED[idx];
        px  = {row.a, row.b, row.g, row.r};
      end else begin
        px = random_pixel();
      end
      // keep offering across the receiver's long hold-off so the pipeline backs up
      gap   = (accepted_px >= HOLD_AT - 20 && accepted_px < HOLD_AT + 180) ? 0 : pick_gap(calm);
      drain = (idx == N_DIRECTED || idx == N_DIRECTED + DRAIN_AT);
      if (drain) gap = gap + 1;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
        while (drain && pending_hsv.size() != 0) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= px;
      do @(posedge clk); while (!in_tready);
      if (idx < N_DIRECTED && row.fixed) pending_hsv.push_back(row.want);
      else pending_hsv.push_back(convert_pixel(px));
      accepted_px++;
    end
    in_tvalid <= 1'b0;
    while (pending_hsv.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (bad_count == 0 && pending_hsv.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // receiver
  initial begin : drive_ready
    int  stall;
    bit  calm;
    bit  held;
    calm = 1'b0;
    held = 1'b0;
    wait (rst_n);
    forever begin
      if ($urandom_range(0, 99) == 0) calm = !calm;
      if (!held && accepted_px >= HOLD_AT) begin
        held  = 1'b1;
        stall = LONG_HOLD;
      end else begin
        stall = pick_gap(calm);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    hsv_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.hue   = out_tdata[8:0];
      got.sat   = out_tdata[16:9];
      got.val   = out_tdata[24:17];
      got.alpha = out_tdata[32:25];
      if (pending_hsv.size() == 0) begin
        bad_count++;
        if (bad_count <= MAX_REPORT)
          $display("unexpected result request: hue %0d sat %0d val %0d alpha %0d",
                   got.hue, got.sat, got.val, got.alpha);
      end else begin
        want = pending_hsv.pop_front();
        if (got !== want || out_tdata[39:33] !== '0) begin
          bad_count++;
          if (bad_count <= MAX_REPORT)
            $display({"hsv mismatch: expected hue %0d sat %0d val %0d alpha %0d, ",
                      "got hue %0d sat %0d val %0d alpha %0d pad %h"},
                     want.hue, want.sat, want.val, want.alpha,
                     got.hue, got.sat, got.val, got.alpha, out_tdata[39:33]);
        end
      end
    end
  end

  // watchdog on lack of progress
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
